// File: sv/tlvp_pkg.sv
// Package for the TLV record parser: parse phases, result kinds and the
// result struct passed from the parse core to the output stage.
// No dependencies.
package tlvp_pkg;

  // Parse phase of the byte stream
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_ID_HI  = 3'd1,
    PH_ID_LO  = 3'd2,
    PH_LENGTH = 3'd3,
    PH_VALUE  = 3'd4
  } phase_e;

  // Result kind codes
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_VALUE  = 1'b1;

  // Header byte field position and length accumulator width
  localparam int unsigned HDR_LONG_ID_BIT = 5;
  localparam int unsigned LEN_ACC_W       = 24;

  // One result beat
  typedef struct packed {
    logic                 item_kind;
    logic [1:0]           record_type;
    logic [15:0]          record_ident;
    logic                 ident_is_long;
    logic [LEN_ACC_W-1:0] value_length;
    logic [7:0]           payload_byte;
    logic                 record_end;
  } result_t;

endpackage

// File: sv/tlvp_if.sv
// Handshake interfaces of the TLV record parser: raw byte input channel and
// result output channel. Depends on tlvp_pkg for the length width.
interface tlvp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tlvp_rec_if;
  logic                          valid;
  logic                          ready;
  logic                          item_kind;
  logic [1:0]                    record_type;
  logic [15:0]                   record_ident;
  logic                          ident_is_long;
  logic [tlvp_pkg::LEN_ACC_W-1:0] value_length;
  logic [7:0]                    payload_byte;
  logic                          record_end;

  modport source (output valid, output item_kind, output record_type,
                  output record_ident, output ident_is_long,
                  output value_length, output payload_byte,
                  output record_end, input ready);
  modport sink   (input valid, input item_kind, input record_type,
                  input record_ident, input ident_is_long,
                  input value_length, input payload_byte,
                  input record_end, output ready);
endinterface

// File: sv/tlvp_parse_core.sv
// Parse core of the TLV record parser: phase state machine, header field
// registers and value byte counter. Depends on tlvp_pkg.
module tlvp_parse_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              beat_i,
  input  logic [7:0]        data_byte_i,
  output logic              res_valid_o,
  output tlvp_pkg::result_t res_o
);

  tlvp_pkg::phase_e                  phase_q, phase_d;
  logic [1:0]                        type_q, type_d;
  logic [15:0]                       ident_q, ident_d;
  logic                              long_q, long_d;
  logic [1:0]                        len_left_q, len_left_d;
  logic [tlvp_pkg::LEN_ACC_W-1:0]    acc_q, acc_d;
  logic [tlvp_pkg::LEN_ACC_W-1:0]    val_left_q, val_left_d;
  logic                              finish;

  // State registers, advanced once per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= tlvp_pkg::PH_HEADER;
      type_q     <= '0;
      ident_q    <= '0;
      long_q     <= 1'b0;
      len_left_q <= '0;
      acc_q      <= '0;
      val_left_q <= '0;
    end else if (beat_i) begin
      phase_q    <= phase_d;
      type_q     <= type_d;
      ident_q    <= ident_d;
      long_q     <= long_d;
      len_left_q <= len_left_d;
      acc_q      <= acc_d;
      val_left_q <= val_left_d;
    end
  end

  // Next state and result for the incoming byte
  always_comb begin
    phase_d     = phase_q;
    type_d      = type_q;
    ident_d     = ident_q;
    long_d      = long_q;
    len_left_d  = len_left_q;
    acc_d       = acc_q;
    val_left_d  = val_left_q;
    finish      = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (phase_q)
      tlvp_pkg::PH_ID_HI: begin
        ident_d = {data_byte_i, 8'h00};
        phase_d = tlvp_pkg::PH_ID_LO;
      end
      tlvp_pkg::PH_ID_LO: begin
        ident_d = {ident_q[15:8], data_byte_i};
        if (len_left_q == 2'd0) begin
          finish = 1'b1;
        end else begin
          acc_d   = '0;
          phase_d = tlvp_pkg::PH_LENGTH;
        end
      end
      tlvp_pkg::PH_LENGTH: begin
        acc_d      = {acc_q[tlvp_pkg::LEN_ACC_W-9:0], data_byte_i};
        len_left_d = len_left_q - 2'd1;
        finish     = (len_left_d == 2'd0);
      end
      tlvp_pkg::PH_VALUE: begin
        val_left_d = val_left_q - {{(tlvp_pkg::LEN_ACC_W-1){1'b0}}, 1'b1};
        if (val_left_d == '0) begin
          phase_d = tlvp_pkg::PH_HEADER;
        end
      end
      default: begin
        // header byte; unused phase codes also land here
        type_d     = data_byte_i[7:6];
        long_d     = data_byte_i[tlvp_pkg::HDR_LONG_ID_BIT];
        len_left_d = data_byte_i[4:3];
        acc_d      = {{(tlvp_pkg::LEN_ACC_W-3){1'b0}}, data_byte_i[2:0]};
        ident_d    = '0;
        val_left_d = '0;
        phase_d    = data_byte_i[tlvp_pkg::HDR_LONG_ID_BIT] ? tlvp_pkg::PH_ID_HI
                                                            : tlvp_pkg::PH_ID_LO;
      end
    endcase

    // Header complete: arm value count, zero length ends the record
    if (finish) begin
      val_left_d = acc_d;
      phase_d    = (acc_d == '0) ? tlvp_pkg::PH_HEADER : tlvp_pkg::PH_VALUE;
    end

    // Result fields reflect the updated header registers
    res_o.record_type   = type_d;
    res_o.record_ident  = ident_d;
    res_o.ident_is_long = long_d;
    res_o.value_length  = acc_d;
    if (finish) begin
      res_valid_o        = 1'b1;
      res_o.item_kind    = tlvp_pkg::KIND_HEADER;
      res_o.payload_byte = 8'h00;
      res_o.record_end   = (acc_d == '0);
    end else if (phase_q == tlvp_pkg::PH_VALUE) begin
      res_valid_o        = 1'b1;
      res_o.item_kind    = tlvp_pkg::KIND_VALUE;
      res_o.payload_byte = data_byte_i;
      res_o.record_end   = (val_left_d == '0);
    end
  end

endmodule

// File: sv/tlv_record_parser.sv
// TLV record parser top level: one byte per beat in, header and value results out.
// Output: a result appears in the output register in the cycle after its byte is taken.
// Throughput: one byte per cycle; the output register is the only stage, and a
// byte is taken whenever that register is empty or is being drained.
// Reset: asynchronous active low; parser returns to expecting a header, output empty.
// Depends on tlvp_pkg, tlvp_if and tlvp_parse_core.
module tlv_record_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  tlvp_byte_if.sink         byte_i,
  tlvp_rec_if.source        rec_o
);

  logic              beat;
  logic              res_valid;
  tlvp_pkg::result_t res;
  logic              out_valid_q, out_valid_d;
  tlvp_pkg::result_t out_q;

  // Take a byte while the output register can accept a result
  assign byte_i.ready = !out_valid_q || rec_o.ready;
  assign beat         = byte_i.valid && byte_i.ready;

  tlvp_parse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .data_byte_i (byte_i.data_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (rec_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (beat && res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (beat && res_valid) begin
      out_q <= res;
    end
  end

  assign rec_o.valid         = out_valid_q;
  assign rec_o.item_kind     = out_q.item_kind;
  assign rec_o.record_type   = out_q.record_type;
  assign rec_o.record_ident  = out_q.record_ident;
  assign rec_o.ident_is_long = out_q.ident_is_long;
  assign rec_o.value_length  = out_q.value_length;
  assign rec_o.payload_byte  = out_q.payload_byte;
  assign rec_o.record_end    = out_q.record_end;

endmodule
